// ===== rtl/svr_pkg.sv =====
// Shared types, constants and codes for the servo PWM block with ramp.
// No dependencies; imported by every module under rtl/.
package svr_pkg;

    // Block dimensions
    localparam int CHANNELS      = 4;
    localparam int RAMP_STEPS    = 10;
    localparam int DUTY_BITS     = 10;
    localparam int INTERVAL_BITS = 16;
    localparam int COUNT_BITS    = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int STEP_BITS     = $clog2(RAMP_STEPS + 1);

    // Register reset values
    localparam logic [DUTY_BITS-1:0]     PERIOD_RESET   = DUTY_BITS'(625);
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(31250);

    // Divide-by-RAMP_STEPS via reciprocal multiply, exact for magnitudes below 2**DUTY_BITS
    localparam int DIV_SH  = DUTY_BITS + $clog2(RAMP_STEPS);
    localparam int DIV_MUL = (2 ** DIV_SH + RAMP_STEPS - 1) / RAMP_STEPS;

    typedef logic [DUTY_BITS-1:0]                t_duty;
    typedef logic signed [DUTY_BITS:0]           t_incr;
    typedef logic [CHANNELS-1:0][DUTY_BITS-1:0]  t_duty_vec;
    typedef logic [INTERVAL_BITS-1:0]            t_interval;
    typedef logic [COUNT_BITS-1:0]               t_count;
    typedef logic [STEP_BITS-1:0]                t_step;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_MOVE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PERIOD   = 2'd0,
        CFG_INTERVAL = 2'd1,
        CFG_ENABLE   = 2'd2
    } t_cfg_idx;

    // Line state after one item
    typedef struct packed {
        logic [CHANNELS-1:0] levels;
        logic                wrap;
    } t_pwm_res;

    // One result item
    typedef struct packed {
        logic [CHANNELS-1:0] levels;
        t_duty_vec           duty;
        logic                busy;
        logic                wrap;
    } t_result;

endpackage

// ===== rtl/servo_pwm_with_ramp_top.sv =====
// Top level of the four-channel servo PWM block with linear ramp.
// Depends on svr_pkg, svr_pwm_core, svr_ramp and svr_out_buf.
//
//  Channel   Signals                                   Handshake
//  input     i_opcode, i_channel_count, i_start_k/end_k i_in_valid / o_in_ready
//  result    o_servo_levels, o_duty_k, o_ramp_active,   o_out_valid / i_out_ready
//            o_frame_wrap
//  config    i_cfg_idx, i_cfg_data                      i_cfg_we (no wait)
//
// One item per clock while o_in_ready is high; its result is registered in the
// output register, or in the skid register when the output is stalled.
// State updates in the transfer cycle, so the next item follows directly.
// A stalled output holds one result and the skid register takes one more;
// o_in_ready falls only when both are full.
// Reset is synchronous, active low, and needs no clearing pass.
module servo_pwm_with_ramp_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [2:0]                    i_channel_count,
    input  logic [9:0]                    i_start_0,
    input  logic [9:0]                    i_end_0,
    input  logic [9:0]                    i_start_1,
    input  logic [9:0]                    i_end_1,
    input  logic [9:0]                    i_start_2,
    input  logic [9:0]                    i_end_2,
    input  logic [9:0]                    i_start_3,
    input  logic [9:0]                    i_end_3,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [3:0]                    o_servo_levels,
    output logic [9:0]                    o_duty_0,
    output logic [9:0]                    o_duty_1,
    output logic [9:0]                    o_duty_2,
    output logic [9:0]                    o_duty_3,
    output logic                          o_ramp_active,
    output logic                          o_frame_wrap,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [svr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [svr_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import svr_pkg::*;

    t_duty     r_period;
    t_interval r_interval;
    logic      r_enable;

    logic      in_xfer;
    logic      tick;
    logic      move;
    logic      enable_wr;
    t_duty_vec start_vec;
    t_duty_vec end_vec;
    t_duty_vec duty_now;
    t_duty_vec duty_next;
    logic      busy_next;
    t_pwm_res  pwm_res;
    t_result   res;
    t_result   out_res;

    // Configuration registers
    always_comb begin
        enable_wr = 1'b0;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE: enable_wr = 1'b1;
                default:    enable_wr = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RESET;
            r_interval <= INTERVAL_RESET;
            r_enable   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PERIOD:   r_period   <= i_cfg_data[DUTY_BITS-1:0];
                CFG_INTERVAL: r_interval <= i_cfg_data[INTERVAL_BITS-1:0];
                CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Item decode; ticks are dropped while disabled
    assign in_xfer   = i_in_valid && o_in_ready;
    assign tick      = in_xfer && (t_opcode'(i_opcode) == OP_TICK) && r_enable;
    assign move      = in_xfer && (t_opcode'(i_opcode) == OP_MOVE);
    assign start_vec = {i_start_3, i_start_2, i_start_1, i_start_0};
    assign end_vec   = {i_end_3, i_end_2, i_end_1, i_end_0};

    svr_ramp u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_move      (move),
        .i_count     (i_channel_count),
        .i_start     (start_vec),
        .i_end       (end_vec),
        .i_interval  (r_interval),
        .o_duty      (duty_now),
        .o_next_duty (duty_next),
        .o_next_busy (busy_next)
    );

    svr_pwm_core u_pwm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_enable    (r_enable),
        .i_enable_wr (enable_wr),
        .i_period    (r_period),
        .i_duty      (duty_now),
        .o_res       (pwm_res)
    );

    // Result assembled from the post-item state
    assign res.levels = pwm_res.levels;
    assign res.duty   = duty_next;
    assign res.busy   = busy_next;
    assign res.wrap   = pwm_res.wrap;

    svr_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_xfer),
        .i_data      (res),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .o_data      (out_res),
        .i_pop_ready (i_out_ready)
    );

    assign o_servo_levels = out_res.levels;
    assign o_duty_0       = out_res.duty[0];
    assign o_duty_1       = out_res.duty[1];
    assign o_duty_2       = out_res.duty[2];
    assign o_duty_3       = out_res.duty[3];
    assign o_ramp_active  = out_res.busy;
    assign o_frame_wrap   = out_res.wrap;

endmodule

// ===== rtl/svr_pwm_core.sv =====
// Period counter and servo line levels.
// Depends on svr_pkg.
module svr_pwm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic                i_enable,
    input  logic                i_enable_wr,
    input  svr_pkg::t_duty      i_period,
    input  svr_pkg::t_duty_vec  i_duty,
    output svr_pkg::t_pwm_res   o_res
);
    import svr_pkg::*;

    logic [DUTY_BITS-1:0] r_cnt,  n_cnt;
    logic [CHANNELS-1:0]  r_lvl,  n_lvl;
    logic [DUTY_BITS-1:0] cnt_inc;
    logic                 wrap;

    // Counter advance, line compares against the pre-tick duties, then the wrap; lines held high while disabled
    always_comb begin
        cnt_inc = r_cnt + DUTY_BITS'(1);
        n_cnt   = r_cnt;
        n_lvl   = r_lvl;
        wrap    = 1'b0;
        if (i_tick) begin
            n_cnt = cnt_inc;
            for (int k = 0; k < CHANNELS; k++) begin
                if (cnt_inc == i_duty[k]) begin
                    n_lvl[k] = 1'b0;
                end
            end
            if (cnt_inc == i_period) begin
                n_cnt = '0;
                n_lvl = '1;
                wrap  = 1'b1;
            end
        end
        if (!i_enable) begin
            n_lvl = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_lvl <= '1;
        end else begin
            r_cnt <= n_cnt;
            // an enable write sets all lines high
            if (i_enable_wr) begin
                r_lvl <= '1;
            end else begin
                r_lvl <= n_lvl;
            end
        end
    end

    assign o_res.levels = n_lvl;
    assign o_res.wrap   = wrap;

endmodule

// ===== rtl/svr_ramp.sv =====
// Ramp engine: per-channel origin and increment, step index, interval timer
// and the compare values. Depends on svr_pkg.
module svr_ramp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic                i_move,
    input  svr_pkg::t_count     i_count,
    input  svr_pkg::t_duty_vec  i_start,
    input  svr_pkg::t_duty_vec  i_end,
    input  svr_pkg::t_interval  i_interval,
    output svr_pkg::t_duty_vec  o_duty,
    output svr_pkg::t_duty_vec  o_next_duty,
    output logic                o_next_busy
);
    import svr_pkg::*;

    localparam int PROD_W = DUTY_BITS + DIV_SH + 1;
    localparam int MUL_W  = DUTY_BITS + STEP_BITS + 2;

    // Signed difference divided by RAMP_STEPS, truncated toward zero
    function automatic t_incr div_steps(input t_incr d);
        logic [DUTY_BITS-1:0] mag;
        logic [PROD_W-1:0]    prod;
        logic [DUTY_BITS-1:0] q;
        mag  = d[DUTY_BITS] ? DUTY_BITS'(-d) : d[DUTY_BITS-1:0];
        prod = PROD_W'(mag) * PROD_W'(DIV_MUL);
        q    = DUTY_BITS'(prod >> DIV_SH);
        return d[DUTY_BITS] ? -signed'({1'b0, q}) : signed'({1'b0, q});
    endfunction

    t_duty_vec            r_cmp,    n_cmp;
    t_duty_vec            r_origin, n_origin;
    t_incr [CHANNELS-1:0] r_inc,    n_inc;
    t_step                r_idx,    n_idx;
    t_interval            r_timer,  n_timer;
    t_count               r_lanes,  n_lanes;
    logic                 r_busy,   n_busy;

    t_interval                timer_inc;
    logic                     move_ok;
    logic                     apply;
    t_incr                    diff;
    logic signed [MUL_W-1:0]  prod;
    logic signed [MUL_W-1:0]  sum;

    always_comb begin
        n_origin  = r_origin;
        n_inc     = r_inc;
        n_idx     = r_idx;
        n_timer   = r_timer;
        n_lanes   = r_lanes;
        n_busy    = r_busy;
        n_cmp     = r_cmp;
        apply     = 1'b0;
        diff      = '0;
        prod      = '0;
        sum       = '0;
        timer_inc = r_timer + INTERVAL_BITS'(1);
        move_ok   = i_move && (i_count != '0) && (int'(i_count) <= CHANNELS);

        // New move restarts the ramp at step 1; a tick may advance a step or end the ramp
        if (move_ok) begin
            for (int k = 0; k < CHANNELS; k++) begin
                if (k < int'(i_count)) begin
                    diff        = signed'({1'b0, i_end[k]}) - signed'({1'b0, i_start[k]});
                    n_origin[k] = i_start[k];
                    n_inc[k]    = div_steps(diff);
                end
            end
            n_lanes = i_count;
            n_idx   = STEP_BITS'(1);
            n_timer = '0;
            n_busy  = 1'b1;
            apply   = 1'b1;
        end else if (i_tick && r_busy) begin
            if (timer_inc == i_interval) begin
                n_timer = '0;
                if (int'(r_idx) < RAMP_STEPS) begin
                    n_idx = r_idx + STEP_BITS'(1);
                    apply = 1'b1;
                end else begin
                    n_busy = 1'b0;
                end
            end else begin
                n_timer = timer_inc;
            end
        end

        // Compare value = origin + increment * step, modulo the duty width
        for (int k = 0; k < CHANNELS; k++) begin
            prod = MUL_W'(n_inc[k]) * MUL_W'(signed'({1'b0, n_idx}));
            sum  = signed'(MUL_W'(n_origin[k])) + prod;
            if (apply && (k < int'(n_lanes))) begin
                n_cmp[k] = sum[DUTY_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp    <= '0;
            r_origin <= '0;
            r_inc    <= '0;
            r_idx    <= '0;
            r_timer  <= '0;
            r_lanes  <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_cmp    <= n_cmp;
            r_origin <= n_origin;
            r_inc    <= n_inc;
            r_idx    <= n_idx;
            r_timer  <= n_timer;
            r_lanes  <= n_lanes;
            r_busy   <= n_busy;
        end
    end

    assign o_duty      = r_cmp;
    assign o_next_duty = n_cmp;
    assign o_next_busy = n_busy;

    // A running ramp always has a valid step and lane count
    a_busy_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != '0) && (int'(r_idx) <= RAMP_STEPS))
        else $error("ramp step index out of range while busy");

    a_busy_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_lanes != '0) && (int'(r_lanes) <= CHANNELS))
        else $error("ramp lane count out of range while busy");

    // A ramp only ends after its last step
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_busy)) |-> (int'($past(r_idx)) == RAMP_STEPS))
        else $error("ramp ended before its final step");

endmodule

// ===== rtl/svr_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on svr_pkg.
module svr_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  svr_pkg::t_result  i_data,
    output logic              o_ready,
    output logic              o_valid,
    output svr_pkg::t_result  o_data,
    input  logic              i_pop_ready
);
    import svr_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= i_push;
                end
            end else if (i_push) begin
                if (r_main_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_main_valid <= 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // The skid entry is only ever behind a held output entry
    a_skid_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry valid without output entry");

endmodule

// ===== tb/tb_servo_pwm_with_ramp_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for servo_pwm_with_ramp_top: directed and random item streams.
// Each transfer is scored against a predictor of the frame counter and the ramp engine.
// Depends on svr_pkg and the RTL under rtl/.
module tb_servo_pwm_with_ramp_top;
    import svr_pkg::*;

    // One input item as the sender holds it
    typedef struct packed {
        t_opcode   op;
        t_count    lanes;
        t_duty_vec from_duty;
        t_duty_vec to_duty;
    } t_servo_cmd;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_opcode;
    logic [2:0]               i_channel_count;
    logic [9:0]               i_start_0, i_end_0, i_start_1, i_end_1;
    logic [9:0]               i_start_2, i_end_2, i_start_3, i_end_3;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [3:0]               o_servo_levels;
    logic [9:0]               o_duty_0, o_duty_1, o_duty_2, o_duty_3;
    logic                     o_ramp_active;
    logic                     o_frame_wrap;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    servo_pwm_with_ramp_top dut (.*);

    // Predictor copy of registers and state
    t_duty               period_reg;
    t_interval           interval_reg;
    logic                enable_reg;
    t_duty               frame_count;
    logic [CHANNELS-1:0] line_state;
    t_duty               compare_val [CHANNELS];
    t_duty               ramp_base   [CHANNELS];
    int                  ramp_delta  [CHANNELS];
    int                  ramp_step;
    t_interval           ramp_timer;
    int                  ramp_width;
    logic                ramp_running;

    t_result pending_servo_results [$];
    int      error_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      move_pct;

    // Clock, 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Result side stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void reset_servo_model();
        period_reg   = PERIOD_RESET;
        interval_reg = INTERVAL_RESET;
        enable_reg   = 1'b1;
        frame_count  = '0;
        line_state   = '1;
        for (int k = 0; k < CHANNELS; k++) begin
            compare_val[k] = '0;
            ramp_base[k]   = '0;
            ramp_delta[k]  = 0;
        end
        ramp_step    = 0;
        ramp_timer   = '0;
        ramp_width   = 0;
        ramp_running = 1'b0;
    endfunction

    // Compare value = base + delta * step, kept to the duty width
    function automatic void apply_ramp_step();
        int v;
        for (int k = 0; k < CHANNELS; k++) begin
            if (k < ramp_width) begin
                v = int'(ramp_base[k]) + ramp_delta[k] * ramp_step;
                compare_val[k] = v[DUTY_BITS-1:0];
            end
        end
    endfunction

    function automatic t_result predict_servo_result(t_servo_cmd c);
        t_result r;
        logic    wrap;
        int      n;
        wrap = 1'b0;
        if (c.op == OP_MOVE) begin
            n = int'(c.lanes);
            if (n != 0 && n <= CHANNELS) begin
                for (int k = 0; k < n; k++) begin
                    ramp_base[k]  = c.from_duty[k];
                    ramp_delta[k] = (int'(c.to_duty[k]) - int'(c.from_duty[k])) / RAMP_STEPS;
                end
                ramp_width   = n;
                ramp_step    = 1;
                ramp_timer   = '0;
                ramp_running = 1'b1;
                apply_ramp_step();
            end
        end else if (enable_reg) begin
            // line compares use the values from before this tick
            frame_count = frame_count + 1'b1;
            for (int k = 0; k < CHANNELS; k++)
                if (frame_count == compare_val[k])
                    line_state[k] = 1'b0;
            if (frame_count == period_reg) begin
                frame_count = '0;
                line_state  = '1;
                wrap        = 1'b1;
            end
            if (ramp_running) begin
                ramp_timer = ramp_timer + 1'b1;
                if (ramp_timer == interval_reg) begin
                    ramp_timer = '0;
                    if (ramp_step < RAMP_STEPS) begin
                        ramp_step++;
                        apply_ramp_step();
                    end else begin
                        ramp_running = 1'b0;
                    end
                end
            end
        end
        if (!enable_reg)
            line_state = '1;
        r.levels = line_state;
        for (int k = 0; k < CHANNELS; k++)
            r.duty[k] = compare_val[k];
        r.busy = ramp_running;
        r.wrap = wrap;
        return r;
    endfunction

    // Item builders
    function automatic t_duty random_duty();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return t_duty'($urandom_range(1023));
        endcase
    endfunction

    function automatic t_servo_cmd tick_cmd();
        t_servo_cmd c;
        c.op    = OP_TICK;
        c.lanes = t_count'($urandom_range(7));
        for (int k = 0; k < CHANNELS; k++) begin
            c.from_duty[k] = random_duty();
            c.to_duty[k]   = random_duty();
        end
        return c;
    endfunction

    function automatic t_servo_cmd random_move(int n);
        t_servo_cmd c;
        c       = tick_cmd();
        c.op    = OP_MOVE;
        c.lanes = t_count'(n);
        return c;
    endfunction

    function automatic t_servo_cmd move_cmd(int n, t_duty_vec from_d, t_duty_vec to_d);
        t_servo_cmd c;
        c.op        = OP_MOVE;
        c.lanes     = t_count'(n);
        c.from_duty = from_d;
        c.to_duty   = to_d;
        return c;
    endfunction

    function automatic t_duty_vec duty4(int d0, int d1, int d2, int d3);
        t_duty_vec v;
        v[0] = t_duty'(d0);
        v[1] = t_duty'(d1);
        v[2] = t_duty'(d2);
        v[3] = t_duty'(d3);
        return v;
    endfunction

    // Mostly ticks; moves mostly name real channels, a few name none or more than exist
    function automatic t_servo_cmd random_cmd();
        int pick;
        if ($urandom_range(99) >= move_pct)
            return tick_cmd();
        pick = $urandom_range(9);
        if (pick == 0) begin
            pick = $urandom_range(3);
            return random_move((pick == 0) ? 0 : pick + 4);
        end
        return random_move($urandom_range(1, 4));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= 50)
            $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // One transfer on the input channel; valid stays up for a following item
    task automatic send_item(t_servo_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= c.op;
        i_channel_count <= c.lanes;
        i_start_0       <= c.from_duty[0];
        i_end_0         <= c.to_duty[0];
        i_start_1       <= c.from_duty[1];
        i_end_1         <= c.to_duty[1];
        i_start_2       <= c.from_duty[2];
        i_end_2         <= c.to_duty[2];
        i_start_3       <= c.from_duty[3];
        i_end_3         <= c.to_duty[3];
        do @(posedge i_clk); while (!o_in_ready);
        pending_servo_results.push_back(predict_servo_result(c));
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(tick_cmd());
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_servo_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_servo_reg(t_cfg_idx idx, int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_BITS'(value);
        @(posedge i_clk);
        case (idx)
            CFG_PERIOD:   period_reg   = t_duty'(value);
            CFG_INTERVAL: interval_reg = t_interval'(value);
            CFG_ENABLE: begin
                enable_reg = value[0];
                line_state = '1;
            end
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Tick until the frame counter wraps, so it starts the next test at zero
    task automatic run_to_wrap();
        int n;
        wait_drained();
        n = int'(t_duty'(period_reg - frame_count));
        if (n == 0)
            n = 1 << DUTY_BITS;
        send_ticks(n);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result   want;
        t_duty_vec got_duty;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_servo_results.size() == 0) begin
                report_mismatch("result with nothing pending, levels", o_servo_levels, 0);
            end else begin
                want     = pending_servo_results.pop_front();
                got_duty = {o_duty_3, o_duty_2, o_duty_1, o_duty_0};
                if (o_servo_levels !== want.levels)
                    report_mismatch("servo_levels", o_servo_levels, want.levels);
                for (int k = 0; k < CHANNELS; k++)
                    if (got_duty[k] !== want.duty[k])
                        report_mismatch($sformatf("duty_%0d", k), got_duty[k], want.duty[k]);
                if (o_ramp_active !== want.busy)
                    report_mismatch("ramp_active", o_ramp_active, want.busy);
                if (o_frame_wrap !== want.wrap)
                    report_mismatch("frame_wrap", o_frame_wrap, want.wrap);
            end
        end
    end

    // Reset values of all registers, then a short ramp at the default interval
    task automatic test_reset_defaults();
        send_ticks(3);
        send_item(move_cmd(2, duty4(100, 900, 0, 0), duty4(200, 100, 0, 0)));
        send_ticks(3);
    endtask

    // Period zero with the counter already above it: the counter runs round the
    // duty width and wraps on rollover; then a short period
    task automatic test_period_rollover();
        send_ticks(5);
        wait_drained();
        write_servo_reg(CFG_PERIOD, 0);
        run_to_wrap();
        wait_drained();
        write_servo_reg(CFG_PERIOD, 3);
        send_ticks(7);
        run_to_wrap();
    endtask

    // Full-scale rising and falling ramps, truncation of negative steps, dead counts
    task automatic test_ramp_extremes();
        wait_drained();
        write_servo_reg(CFG_PERIOD, 1);
        write_servo_reg(CFG_INTERVAL, 1);
        send_item(move_cmd(4, duty4(0, 1023, 1000, 5), duty4(1023, 0, 15, 0)));
        send_ticks(12);
        send_item(random_move(0));
        send_item(random_move(5));
        send_item(random_move(7));
        // compare value equal to the period: the line falls and the wrap raises it
        send_item(move_cmd(1, duty4(1, 0, 0, 0), duty4(1, 0, 0, 0)));
        send_ticks(2);
    endtask

    // A new move while busy restarts the ramp; unnamed channels keep their values
    task automatic test_move_restart();
        wait_drained();
        write_servo_reg(CFG_PERIOD, 20);
        write_servo_reg(CFG_INTERVAL, 3);
        send_item(random_move(4));
        send_ticks(4);
        send_item(random_move(1));
        send_ticks(7);
        send_item(random_move(2));
        send_ticks(1);
    endtask

    // Disabled: ticks ignored, lines high, moves still take their first step
    task automatic test_disabled();
        run_to_wrap();
        wait_drained();
        write_servo_reg(CFG_PERIOD, 1023);
        write_servo_reg(CFG_ENABLE, 0);
        send_ticks(3);
        send_item(move_cmd(3, duty4(2, 3, 4, 0), duty4(2, 3, 4, 0)));
        send_ticks(3);
        wait_drained();
        write_servo_reg(CFG_ENABLE, 1);
        send_ticks(6);
        // rewriting enable raises the lines even while running
        wait_drained();
        write_servo_reg(CFG_ENABLE, 1);
        send_ticks(2);
    endtask

    // Longest interval, and zero which behaves as 65536 ticks: no early step
    task automatic test_interval_extremes();
        wait_drained();
        write_servo_reg(CFG_ENABLE, 1);
        write_servo_reg(CFG_INTERVAL, 65535);
        send_item(random_move(2));
        send_ticks(40);
        wait_drained();
        write_servo_reg(CFG_INTERVAL, 0);
        send_item(random_move(1));
        send_ticks(40);
    endtask

    task automatic randomise_config();
        int p;
        wait_drained();
        case ($urandom_range(9))
            0:       p = 1;
            1:       p = 1023;
            2, 3:    p = $urandom_range(41, 1023);
            default: p = $urandom_range(2, 40);
        endcase
        write_servo_reg(CFG_PERIOD, p);
        if ($urandom_range(9) == 0)
            write_servo_reg(CFG_INTERVAL, $urandom_range(7, 300));
        else
            write_servo_reg(CFG_INTERVAL, $urandom_range(1, 6));
        write_servo_reg(CFG_ENABLE, ($urandom_range(7) == 0) ? 0 : 1);
        case ($urandom_range(2))
            0:       move_pct = 3;
            1:       move_pct = 12;
            default: move_pct = 30;
        endcase
    endtask

    // Random items in three settings per idling profile
    task automatic run_random_phase(int send_pct, int recv_pct, int n_items);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int seg = 0; seg < 3; seg++) begin
            randomise_config();
            repeat (n_items / 3) send_item(random_cmd());
        end
    endtask

    // Run timeout
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence
    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_opcode        = OP_TICK;
        i_channel_count = '0;
        i_start_0       = '0;
        i_end_0         = '0;
        i_start_1       = '0;
        i_end_1         = '0;
        i_start_2       = '0;
        i_end_2         = '0;
        i_start_3       = '0;
        i_end_3         = '0;
        i_out_ready     = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_PERIOD;
        i_cfg_data      = '0;
        error_count     = 0;
        move_pct        = 12;
        send_idle_pct   = 29;
        recv_idle_pct   = 55;
        reset_servo_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_period_rollover();
        test_ramp_extremes();
        test_move_restart();
        test_disabled();
        run_random_phase(29, 55, 90);
        run_random_phase(55, 29, 90);
        run_random_phase(0, 0, 90);
        test_interval_extremes();

        // drain, then allow for the output register
        i_in_valid <= 1'b0;
        for (int i = 0; i < 5000 && pending_servo_results.size() != 0; i++)
            @(posedge i_clk);
        if (pending_servo_results.size() != 0)
            report_mismatch("results never delivered, count", 0,
                            pending_servo_results.size());
        repeat (4) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== servo_pwm_with_ramp_top.f =====
rtl/svr_pkg.sv
rtl/svr_pwm_core.sv
rtl/svr_ramp.sv
rtl/svr_out_buf.sv
rtl/servo_pwm_with_ramp_top.sv
tb/tb_servo_pwm_with_ramp_top.sv
